@@ rtl/qse_pkg.sv @@
// ----------------------------------------------------------------------------
// qse_pkg
// Shared types and constants of the quoted string escaper.
// ----------------------------------------------------------------------------
package qse_pkg;

    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_DATA  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_EOL   = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_SPECIALS_RAW = 2'd0;
    localparam logic [1:0] CFG_WRAP_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_MULTILINE    = 2'd2;
    localparam logic [1:0] CFG_LINE_LENGTH  = 2'd3;

    localparam int CFG_DATA_W = 7;
    localparam logic [6:0] LINE_LENGTH_RESET = 7'd70;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    // Main part of a job
    typedef enum logic [1:0] {
        K_NONE    = 2'd0,
        K_NEWLINE = 2'd1,
        K_UNIT    = 2'd2
    } kind_t;

    // One classified item, handed from front to back
    typedef struct packed {
        logic        flush;     // emit held \r escape first
        kind_t       kind;
        logic [2:0]  len;       // unit length, 1, 2 or 4
        logic [31:0] chars;     // unit characters, first in [7:0]
    } desc_t;

    localparam int DESC_W = $bits(desc_t);
    localparam int OUT_W  = 9;

    localparam int DESC_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF  = 2;

endpackage

@@ rtl/quoted_string_escaper_with_wrap.sv @@
// ----------------------------------------------------------------------------
// quoted_string_escaper_with_wrap
// Turns a byte stream into a quoted, escaped string, one character a word.
// ----------------------------------------------------------------------------
// A word is taken on every cycle the input queue has room (push && !full);
// the front end classifies it and drops a job into a short queue. The back
// end sends one character per cycle into the result queue while it has
// room. A word makes 1 character for plain text, 2 for a short escape, 4
// for an octal escape, up to 10 with a flushed CR and two continuation
// breaks. Sustained rate is set by that back end sequencer.
// A multiline CR that is held makes no character and takes no back end time.
// Write configuration only while the block is idle.
module quoted_string_escaper_with_wrap
    import qse_pkg::*;
#(
    parameter int DESC_DEPTH = DESC_DEPTH_DEF,
    parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            operation,
    input  logic [7:0]            char_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            out_char,
    output logic                  last
);

    logic       specials_raw_reg;
    logic       wrap_enable_reg;
    logic       multiline_reg;
    logic [6:0] line_length_reg;

    logic       accept;
    logic       job_valid;
    desc_t      job_wr;
    desc_t      job_rd;
    logic       job_empty;
    logic       job_pop;
    logic       out_full;
    logic       out_push;
    logic [7:0] back_char;
    logic       back_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            specials_raw_reg <= 1'b0;
            wrap_enable_reg  <= 1'b0;
            multiline_reg    <= 1'b0;
            line_length_reg  <= LINE_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SPECIALS_RAW: specials_raw_reg <= cfg_data[0];
                CFG_WRAP_ENABLE:  wrap_enable_reg  <= cfg_data[0];
                CFG_MULTILINE:    multiline_reg    <= cfg_data[0];
                CFG_LINE_LENGTH:  line_length_reg  <= cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    assign accept = push && !full;

    qse_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (operation),
        .char_byte    (char_byte),
        .specials_raw (specials_raw_reg),
        .multiline    (multiline_reg),
        .job_valid    (job_valid),
        .job          (job_wr)
    );

    qse_fifo #(
        .WIDTH (DESC_W),
        .DEPTH (DESC_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_data (job_wr),
        .rd_en   (job_pop),
        .rd_data (job_rd),
        .full    (full),
        .empty   (job_empty)
    );

    qse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_in      (job_rd),
        .job_empty   (job_empty),
        .job_pop     (job_pop),
        .wrap_enable (wrap_enable_reg),
        .line_length (line_length_reg),
        .out_full    (out_full),
        .out_push    (out_push),
        .out_char    (back_char),
        .out_last    (back_last)
    );

    qse_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data ({back_last, back_char}),
        .rd_en   (pop),
        .rd_data ({last, out_char}),
        .full    (out_full),
        .empty   (empty)
    );

endmodule

@@ rtl/qse_fifo.sv @@
// ----------------------------------------------------------------------------
// qse_fifo
// Small register FIFO with first-word-fall-through read.
// ----------------------------------------------------------------------------
module qse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/qse_front.sv @@
// ----------------------------------------------------------------------------
// qse_front
// Classifies each input word into an escape job and tracks a held CR.
// ----------------------------------------------------------------------------
module qse_front
    import qse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [1:0]  operation,
    input  logic [7:0]  char_byte,
    input  logic        specials_raw,
    input  logic        multiline,
    output logic        job_valid,
    output desc_t       job
);

    logic pending_reg, pending_next;
    op_t  op;
    logic octal;

    assign op    = op_t'(operation);
    assign octal = (char_byte < CH_SPACE) || (char_byte == 8'hFF)
                   || (char_byte[7] && !specials_raw);

    always_comb
    begin
        job.flush    = pending_reg;
        job.kind     = K_UNIT;
        job.len      = 3'd1;
        job.chars    = {24'd0, CH_QUOTE};
        pending_next = 1'b0;

        if (op == OP_DATA && pending_reg && char_byte == CH_LF)
        begin
            // CR LF pair becomes a real line break
            job.flush = 1'b0;
            job.kind  = K_NEWLINE;
        end
        else
        begin
            unique case (op)
                OP_OPEN, OP_CLOSE:
                begin
                    job.chars = {24'd0, CH_QUOTE};
                end
                OP_EOL:
                begin
                    job.kind = K_NEWLINE;
                end
                OP_DATA:
                begin
                    if (char_byte == CH_CR)
                    begin
                        if (multiline)
                        begin
                            pending_next = 1'b1;
                            job.kind     = K_NONE;
                        end
                        else
                        begin
                            job.len   = 3'd2;
                            job.chars = {16'd0, CH_R, CH_BSLASH};
                        end
                    end
                    else if (char_byte == CH_LF)
                    begin
                        job.len   = 3'd2;
                        job.chars = {16'd0, CH_N, CH_BSLASH};
                    end
                    else if (char_byte == CH_BSLASH || char_byte == CH_QUOTE)
                    begin
                        job.len   = 3'd2;
                        job.chars = {16'd0, char_byte, CH_BSLASH};
                    end
                    else if (octal)
                    begin
                        job.len   = 3'd4;
                        job.chars = {5'b00110, char_byte[2:0],
                                     5'b00110, char_byte[5:3],
                                     6'b001100, char_byte[7:6], CH_BSLASH};
                    end
                    else
                    begin
                        job.chars = {24'd0, char_byte};
                    end
                end
                default:
                begin
                    job.kind = K_NONE;
                end
            endcase
        end
    end

    // Words that produce no character never reach the back end
    assign job_valid = accept && (job.flush || job.kind != K_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
        end
    end

endmodule

@@ rtl/qse_back.sv @@
// ----------------------------------------------------------------------------
// qse_back
// Walks one escape job a character per cycle while the output has room,
// tracks the column and inserts continuation breaks.
// ----------------------------------------------------------------------------
module qse_back
    import qse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  desc_t       job_in,
    input  logic        job_empty,
    output logic        job_pop,
    input  logic        wrap_enable,
    input  logic [6:0]  line_length,
    input  logic        out_full,
    output logic        out_push,
    output logic [7:0]  out_char,
    output logic        out_last
);

    typedef enum logic [1:0] {
        PH_FLUSH,
        PH_FBRK,
        PH_MAIN,
        PH_MBRK
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       active_reg, active_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] col_reg, col_next;
    desc_t      job_reg, job_next;

    logic       is_nl;
    logic [2:0] cur_len;
    logic [7:0] sum;
    logic       brk;
    logic       unit_end;
    logic       emit;
    logic       done;
    logic       load;

    assign is_nl = (phase_reg == PH_MAIN) && (job_reg.kind == K_NEWLINE);
    assign emit  = active_reg && !out_full;

    always_comb
    begin
        if (phase_reg == PH_MAIN)
        begin
            cur_len = is_nl ? 3'd1 : job_reg.len;
        end
        else
        begin
            cur_len = 3'd2;
        end
    end

    // Column stays unchanged through a unit, so the break decision holds
    assign sum      = col_reg + 8'(cur_len);
    assign brk      = wrap_enable && !is_nl && (sum > {1'b0, line_length});
    assign unit_end = (phase_reg == PH_FLUSH || phase_reg == PH_MAIN)
                      && (3'(idx_reg) == cur_len - 3'd1);

    always_comb
    begin
        case (phase_reg)
            PH_FLUSH:
                out_char = (idx_reg == 2'd0) ? CH_BSLASH : CH_R;
            PH_MAIN:
            begin
                if (is_nl)
                begin
                    out_char = CH_LF;
                end
                else
                begin
                    case (idx_reg)
                        2'd0:    out_char = job_reg.chars[7:0];
                        2'd1:    out_char = job_reg.chars[15:8];
                        2'd2:    out_char = job_reg.chars[23:16];
                        default: out_char = job_reg.chars[31:24];
                    endcase
                end
            end
            default:
                out_char = (idx_reg == 2'd0) ? CH_BSLASH : CH_LF;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        col_next    = col_reg;
        job_next    = job_reg;
        active_next = active_reg;
        done        = 1'b0;

        if (emit)
        begin
            unique case (phase_reg)
                PH_FLUSH:
                begin
                    if (!unit_end)
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                    else if (brk)
                    begin
                        phase_next = PH_FBRK;
                        idx_next   = 2'd0;
                    end
                    else if (job_reg.kind == K_NONE)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_MAIN;
                        idx_next   = 2'd0;
                    end
                end
                PH_FBRK:
                begin
                    if (idx_reg == 2'd0)
                    begin
                        idx_next = 2'd1;
                    end
                    else if (job_reg.kind == K_NONE)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_MAIN;
                        idx_next   = 2'd0;
                    end
                end
                PH_MAIN:
                begin
                    if (!unit_end)
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                    else if (brk)
                    begin
                        phase_next = PH_MBRK;
                        idx_next   = 2'd0;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                PH_MBRK:
                begin
                    if (idx_reg == 2'd0)
                    begin
                        idx_next = 2'd1;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase

            if (unit_end)
            begin
                if (is_nl)
                begin
                    col_next = 8'd0;
                end
                else if (wrap_enable)
                begin
                    col_next = brk ? 8'd0 : sum;
                end
            end
        end

        load = !active_reg || (emit && done);
        if (load)
        begin
            active_next = !job_empty;
            job_next    = job_in;
            phase_next  = job_in.flush ? PH_FLUSH : PH_MAIN;
            idx_next    = 2'd0;
        end
    end

    assign job_pop  = load && !job_empty;
    assign out_push = emit;
    assign out_last = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAIN;
            active_reg <= 1'b0;
            idx_reg    <= 2'd0;
            col_reg    <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            active_reg <= active_next;
            idx_reg    <= idx_next;
            col_reg    <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

@@ rtl/qse_checker.sv @@
// ----------------------------------------------------------------------------
// qse_checker
// Port-level checks of the escaper, bound to the top level.
// ----------------------------------------------------------------------------
module qse_checker
    import qse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [7:0]            out_char,
    input  logic                  last
);

    logic [3:0] run_reg;
    logic       wrap_reg;
    logic       take;

    assign take = pop && !empty;

    // characters taken since the last word-final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 4'd0;
            wrap_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                run_reg <= last ? 4'd0 : ((run_reg == 4'hF) ? run_reg : run_reg + 4'd1);
            end
            if (cfg_wr_en && cfg_index == CFG_WRAP_ENABLE)
            begin
                wrap_reg <= cfg_data[0];
            end
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_char) && $stable(last))
        else $error("result word changed while waiting");

    a_max_run: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> run_reg <= 4'd9)
        else $error("more than ten characters for one input word");

    a_nowrap_run: assert property (@(posedge clk) disable iff (!rst_n)
        take && !wrap_reg |-> run_reg <= 4'd5)
        else $error("continuation break with wrapping off");

endmodule

bind quoted_string_escaper_with_wrap qse_checker u_qse_checker (.*);
